>>> rtl/indexed_shift_array_assert.svh
// Assertion macros for the indexed shift array checker.
// Depends on nothing; the using module supplies clk and rst.
`ifndef INDEXED_SHIFT_ARRAY_ASSERT_SVH
`define INDEXED_SHIFT_ARRAY_ASSERT_SVH

// Clocked check that is switched off while reset is high
`define ISA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset
`define ISA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/isa_pkg.sv
// Shared types and constants for the indexed shift array.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package isa_pkg;

  localparam int unsigned DATA_W   = 64;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned CAP_DEF  = 64;
  localparam int unsigned CAP_MAX  = 4096;
  // position width that covers any capacity in range
  localparam int unsigned POS_W    = $clog2(CAP_MAX + 1);
  // reachable positions through the index field
  localparam int unsigned IDX_SPAN = 1 << IDX_W;
  // leaves per group of the read tree
  localparam int unsigned LEAF_N   = 8;

  localparam logic [DATA_W-1:0] QUIET_NAN = 64'h7FF8_0000_0000_0000;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH     = 3'd0,
    MODE_INSERT   = 3'd1,
    MODE_ERASE    = 3'd2,
    MODE_MODIFY   = 3'd3,
    MODE_RETRIEVE = 3'd4,
    MODE_CLEAR    = 3'd5
  } isa_mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } isa_status_t;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD     = 2'd0,
    OP_LOAD     = 2'd1,
    OP_SHIFT_UP = 2'd2,
    OP_SHIFT_DN = 2'd3
  } isa_op_t;

  typedef struct packed {
    isa_op_t          op;
    logic [POS_W-1:0] pos;
  } isa_cmd_t;

  // per-item result information beside the read word
  typedef struct packed {
    isa_status_t status;
    logic        nan;
    logic        rd_en;
  } isa_res_t;

endpackage

>>> rtl/isa_cell.sv
// One storage cell of the shift chain: holds a word, loads the item value
// or takes a neighbor's word as the broadcast command says. Uses isa_pkg.
`timescale 1ns / 1ps

module isa_cell
  import isa_pkg::*;
#(
  parameter int unsigned SLOT = 0
) (
  input  logic              clk,
  input  isa_cmd_t          cmd,
  input  logic [DATA_W-1:0] value,
  input  logic [DATA_W-1:0] left,
  input  logic [DATA_W-1:0] right,
  output logic [DATA_W-1:0] q
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(SLOT);

  // update the held word; payload needs no reset
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        if (MY_POS == cmd.pos) q <= value;
      end
      OP_SHIFT_UP: begin
        if (MY_POS > cmd.pos) begin
          q <= left;
        end else if (MY_POS == cmd.pos) begin
          q <= value;
        end
      end
      OP_SHIFT_DN: begin
        if (MY_POS >= cmd.pos) q <= right;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/isa_ctrl.sv
// Operation decode and entry count for the indexed shift array.
// Produces the cell command and the result status. Uses isa_pkg.
`timescale 1ns / 1ps

module isa_ctrl
  import isa_pkg::*;
#(
  parameter int unsigned CAPACITY = CAP_DEF,
  parameter int unsigned CNT_W    = $clog2(CAP_DEF + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [MODE_W-1:0] mode,
  input  logic [IDX_W-1:0]  idx,
  output isa_cmd_t          cmd,
  output isa_res_t          res,
  output logic [CNT_W-1:0]  count_next
);

  logic [CNT_W-1:0] count;
  logic [POS_W-1:0] cnt_ext;
  logic [POS_W-1:0] idx_ext;
  logic             full;
  logic             empty;
  isa_op_t          op;
  logic [POS_W-1:0] pos;
  logic [CNT_W-1:0] cnt_dec;

  assign cnt_ext = POS_W'(count);
  assign idx_ext = POS_W'(idx);
  assign full    = (cnt_ext == POS_W'(CAPACITY));
  assign empty   = (count == '0);

  // decode the item against the current count
  always_comb begin
    op          = OP_HOLD;
    pos         = idx_ext;
    res.status  = ST_OK;
    res.nan     = 1'b0;
    res.rd_en   = 1'b0;
    cnt_dec     = count;
    unique case (mode)
      MODE_PUSH: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          op      = OP_LOAD;
          pos     = cnt_ext;
          cnt_dec = count + CNT_W'(1);
        end
      end
      MODE_INSERT: begin
        if (full) begin
          res.status = ST_FULL;
        end else if (idx_ext > cnt_ext) begin
          res.status = ST_RANGE;
        end else begin
          op      = OP_SHIFT_UP;
          cnt_dec = count + CNT_W'(1);
        end
      end
      MODE_ERASE: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else if (idx_ext >= cnt_ext) begin
          res.status = ST_RANGE;
        end else begin
          op      = OP_SHIFT_DN;
          cnt_dec = count - CNT_W'(1);
        end
      end
      MODE_MODIFY: begin
        if (idx_ext >= cnt_ext) begin
          res.status = ST_RANGE;
        end else begin
          op = OP_LOAD;
        end
      end
      MODE_RETRIEVE: begin
        if (idx_ext >= cnt_ext) begin
          res.status = ST_RANGE;
          res.nan    = 1'b1;
        end else begin
          res.rd_en = 1'b1;
        end
      end
      MODE_CLEAR: begin
        cnt_dec = '0;
      end
      default: begin
      end
    endcase
  end

  // cells move only on an accepted transfer
  assign cmd.op     = accept ? op : OP_HOLD;
  assign cmd.pos    = pos;
  assign count_next = cnt_dec;

  // hold the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= cnt_dec;
    end
  end

endmodule

>>> rtl/indexed_shift_array.sv
// Channel  | Dir | Fields (tdata, lowest bit first)
// s_*      | in  | mode[2:0], index[8:3], value[72:9], zero pad to 80 bits
// m_*      | out | read_value[63:0], status[65:64], count, is_empty, zero pad
//
// One item is taken per cycle while s_tready is high; its result passes the
// read stage register, after the first read tree level, then the output register.
// All cells shift in parallel in the cycle of the transfer.
// Reset clears the count and the valid flags; cell contents are left as is.
// A stalled output holds its result and lets one more item into the read
// stage before s_tready drops.
//
// Top level of the indexed shift array; uses isa_pkg, isa_ctrl, isa_cell.
`timescale 1ns / 1ps

module indexed_shift_array
  import isa_pkg::*;
#(
  parameter int unsigned CAPACITY = CAP_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // mode, index, value, zero pad
  input  logic [79:0]          s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // read_value, status, count, is_empty, zero pad
  output logic [((DATA_W + STAT_W + $clog2(CAPACITY + 1) + 1 + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned OUT_BITS = DATA_W + STAT_W + CNT_W + 1;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned RD_N     = (CAPACITY < IDX_SPAN) ? CAPACITY : IDX_SPAN;
  localparam int unsigned NGRP     = (RD_N + LEAF_N - 1) / LEAF_N;
  localparam int unsigned IDX_LSB  = MODE_W;
  localparam int unsigned VAL_LSB  = MODE_W + IDX_W;

  logic                accept;
  logic                adv_out;
  logic [MODE_W-1:0]   in_mode;
  logic [IDX_W-1:0]    in_idx;
  logic [DATA_W-1:0]   in_value;
  isa_cmd_t            cmd;
  isa_res_t            res;
  logic [CNT_W-1:0]    count_next;

  logic [DATA_W-1:0]   cell_q  [CAPACITY];
  logic [DATA_W-1:0]   cell_lt [CAPACITY];
  logic [DATA_W-1:0]   cell_rt [CAPACITY];
  logic [DATA_W-1:0]   leaf    [NGRP*LEAF_N];
  logic [DATA_W-1:0]   grp_next[NGRP];

  logic                s1_valid;
  isa_res_t            s1_res;
  logic [CNT_W-1:0]    s1_count;
  logic [DATA_W-1:0]   s1_grp  [NGRP];
  logic [DATA_W-1:0]   rd_or;

  logic [DATA_W-1:0]   out_value;
  isa_status_t         out_status;
  logic [CNT_W-1:0]    out_count;
  logic                out_empty;

  // unpack the input transfer
  assign in_mode  = s_tdata[MODE_W-1:0];
  assign in_idx   = s_tdata[IDX_LSB +: IDX_W];
  assign in_value = s_tdata[VAL_LSB +: DATA_W];

  // handshake: the read stage empties into the output register
  assign adv_out  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || adv_out;
  assign accept   = s_tvalid && s_tready;

  isa_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .mode       (in_mode),
    .idx        (in_idx),
    .cmd        (cmd),
    .res        (res),
    .count_next (count_next)
  );

  // chain of cells, each wired to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_lt0
      assign cell_lt[i] = '0;
    end else begin : g_lt
      assign cell_lt[i] = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_rt0
      assign cell_rt[i] = '0;
    end else begin : g_rt
      assign cell_rt[i] = cell_q[i+1];
    end
    isa_cell #(
      .SLOT (i)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .value (in_value),
      .left  (cell_lt[i]),
      .right (cell_rt[i]),
      .q     (cell_q[i])
    );
  end

  // select the addressed cell at the leaves of the read tree
  for (genvar i = 0; i < NGRP * LEAF_N; i++) begin : g_leaf
    if (i < RD_N) begin : g_used
      assign leaf[i] = (in_idx == IDX_W'(i)) ? cell_q[i] : '0;
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  // first tree level: merge each group of leaves
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < LEAF_N; k++) begin
        grp_next[g] = grp_next[g] | leaf[g*LEAF_N + k];
      end
    end
  end

  // second tree level: merge the registered groups
  always_comb begin
    rd_or = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_or = rd_or | s1_grp[g];
    end
  end

  // read stage valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv_out) begin
      s1_valid <= 1'b0;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res   <= res;
      s1_count <= count_next;
      for (int g = 0; g < NGRP; g++) begin
        s1_grp[g] <= grp_next[g];
      end
    end
  end

  // output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (adv_out) begin
      if (s1_res.nan) begin
        out_value <= QUIET_NAN;
      end else if (s1_res.rd_en) begin
        out_value <= rd_or;
      end else begin
        out_value <= '0;
      end
      out_status <= s1_res.status;
      out_count  <= s1_count;
      out_empty  <= (s1_count == '0);
    end
  end

  assign m_tdata = OUT_W'({out_empty, out_count, out_status, out_value});

endmodule

>>> rtl/isa_checker.sv
// Port-level checks for the indexed shift array, bound to the top level.
// Depends on isa_pkg and indexed_shift_array_assert.svh.
`timescale 1ns / 1ps
`include "indexed_shift_array_assert.svh"

module isa_checker
  import isa_pkg::*;
#(
  parameter int unsigned CAPACITY = CAP_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [((DATA_W + STAT_W + $clog2(CAPACITY + 1) + 1 + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned ST_LSB  = DATA_W;
  localparam int unsigned CNT_LSB = DATA_W + STAT_W;
  localparam int unsigned EMP_BIT = DATA_W + STAT_W + CNT_W;

  logic [DATA_W-1:0] rd_value;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  count;
  logic              is_empty;

  assign rd_value = m_tdata[DATA_W-1:0];
  assign status   = m_tdata[ST_LSB +: STAT_W];
  assign count    = m_tdata[CNT_LSB +: CNT_W];
  assign is_empty = m_tdata[EMP_BIT];

  // a stalled result stays put
  `ISA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

  // the empty flag tracks the count
  `ISA_ASSERT(a_empty_flag, m_tvalid |-> (is_empty == (count == '0)), "empty flag disagrees with count")

  // the count never passes the capacity
  `ISA_ASSERT(a_count_cap, m_tvalid |-> (count <= CNT_W'(CAPACITY)), "count above capacity")

  // a dropped item on a full store reads back zero
  `ISA_ASSERT(a_full_zero, m_tvalid && (status == ST_FULL) |-> (rd_value == '0), "full status with nonzero word")

  // no result right after reset
  `ISA_ASSERT_RST(a_rst_idle, $past(rst) |-> !m_tvalid, "result valid after reset")

endmodule

bind indexed_shift_array isa_checker #(.CAPACITY(CAPACITY)) u_isa_checker (.*);
